// File: src/mbet_pkg.sv
package mbet_pkg;

   // view geometry, both must be powers of two
   localparam int HEIGHT      = 512;
   localparam int WIDTH       = 512;
   localparam int HEIGHT_LOG2 = $clog2(HEIGHT);
   localparam int WIDTH_LOG2  = $clog2(WIDTH);

   localparam int FRAC_BITS  = 28;
   localparam int COORD_W    = 9;
   localparam int PIX_W      = 18;
   localparam int COUNT_W    = 16;
   localparam int GRAY_W     = 8;
   localparam int CSR_DATA_W = 31;
   localparam int CSR_IDX_W  = 2;
   localparam int ACC_W      = 48;

   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_REAL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_IMAG = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AREA_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ITER    = 2'd3;

   localparam logic [30:0]        RST_CENTER_REAL = 31'd0;
   localparam logic [30:0]        RST_CENTER_IMAG = 31'd0;
   localparam logic [30:0]        RST_AREA_WIDTH  = 31'd1073741824;
   localparam logic [COUNT_W-1:0] RST_MAX_ITER    = 16'd256;

   // 4.0 in Q4.28
   localparam logic signed [ACC_W-1:0] ESCAPE_LIMIT = 48'sh0000_4000_0000;

   typedef struct packed {
      logic [30:0]        center_real;
      logic [30:0]        center_imag;
      logic [30:0]        area_width;
      logic [COUNT_W-1:0] max_iter;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_ROW,
      ST_MUL_COL,
      ST_FIRST_SQ,
      ST_SQ_A,
      ST_SQ_B,
      ST_PROD_AB,
      ST_TEST
   } state_type;

   typedef enum logic [2:0] {
      MUL_STEP_ROW,
      MUL_STEP_COL,
      MUL_A_A,
      MUL_B_B,
      MUL_A_B
   } mul_sel_type;

   typedef struct packed {
      mul_sel_type mul_sel;
      logic        load_cr;
      logic        load_ci;
      logic        load_aa;
      logic        load_bb;
      logic        iterate;
      logic        done;
   } ctrl_type;

   function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
      logic signed [ACC_W-1:0] hi;
      logic signed [ACC_W-1:0] lo;
      hi = 48'sh0000_7FFF_FFFF;
      lo = -48'sh0000_8000_0000;
      if (x > hi) begin
         return 32'sh7FFF_FFFF;
      end else if (x < lo) begin
         return 32'sh8000_0000;
      end
      return x[31:0];
   endfunction

endpackage

// File: src/mbet_mul.sv
module mbet_mul (
   input  logic                clock,
   input  logic signed [31:0]  op_a,
   input  logic signed [31:0]  op_b,
   output logic signed [63:0]  prod_ff
);
   logic signed [63:0] prod_in;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end
endmodule

// File: src/mbet_core.sv
module mbet_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [mbet_pkg::COORD_W-1:0]  row,
   input  logic [mbet_pkg::COORD_W-1:0]  col,
   input  mbet_pkg::cfg_type             cfg,
   input  logic                          out_free,
   output logic                          busy,
   output logic                          done,
   output logic [mbet_pkg::PIX_W-1:0]    pixel_index,
   output logic [mbet_pkg::COUNT_W-1:0]  escape_count
);
   import mbet_pkg::*;

   state_type state_ff, state_in;
   ctrl_type  ctrl;

   logic [COORD_W-1:0]   row_ff, col_ff;
   logic signed [31:0]   cr_ff, ci_ff, a_ff, b_ff;
   logic signed [35:0]   aa_ff, bb_ff;
   logic [COUNT_W-1:0]   n_ff;

   logic signed [31:0]   mul_a, mul_b;
   logic signed [63:0]   prod;
   logic [30:0]          step;
   logic [30:0]          half;
   logic [30:0]          c_center;
   logic [ACC_W-1:0]     c_sum;
   logic signed [35:0]   prod_q;
   logic signed [ACC_W-1:0] mag, na_sum, nb_sum;
   logic                 stop;

   assign step = cfg.area_width >> HEIGHT_LOG2;
   assign half = cfg.area_width >> 1;

   // product in Q4.28, floor rounding
   assign prod_q = prod[63:FRAC_BITS];

   // real centre while loading c_re, imaginary centre while loading c_im
   assign c_center = ctrl.load_ci ? cfg.center_imag : cfg.center_real;

   assign c_sum  = ACC_W'($signed(c_center)) - ACC_W'(half) + prod[ACC_W-1:0];
   assign mag    = ACC_W'(aa_ff) + ACC_W'(bb_ff);
   assign na_sum = (ACC_W'(prod_q) <<< 1) + ACC_W'(cr_ff);
   assign nb_sum = ACC_W'(bb_ff) - ACC_W'(aa_ff) + ACC_W'(ci_ff);
   assign stop   = (mag > ESCAPE_LIMIT) || (n_ff >= cfg.max_iter);

   always_comb begin
      unique case (ctrl.mul_sel)
         MUL_STEP_ROW: begin
            mul_a = $signed({1'b0, step});
            mul_b = $signed(32'(row_ff));
         end
         MUL_STEP_COL: begin
            mul_a = $signed({1'b0, step});
            mul_b = $signed(32'(col_ff));
         end
         MUL_A_A: begin
            mul_a = a_ff;
            mul_b = a_ff;
         end
         MUL_B_B: begin
            mul_a = b_ff;
            mul_b = b_ff;
         end
         default: begin
            mul_a = a_ff;
            mul_b = b_ff;
         end
      endcase
   end

   mbet_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (start) state_in = ST_MUL_ROW;
         ST_MUL_ROW:  state_in = ST_MUL_COL;
         ST_MUL_COL:  state_in = ST_FIRST_SQ;
         ST_FIRST_SQ: state_in = ST_SQ_B;
         ST_SQ_A:     state_in = ST_SQ_B;
         ST_SQ_B:     state_in = ST_PROD_AB;
         ST_PROD_AB:  state_in = ST_TEST;
         ST_TEST: begin
            priority if (!stop) begin
               state_in = ST_SQ_A;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      ctrl = '{mul_sel: MUL_A_B, load_cr: 1'b0, load_ci: 1'b0, load_aa: 1'b0,
               load_bb: 1'b0, iterate: 1'b0, done: 1'b0};
      unique case (state_ff)
         ST_IDLE:     ctrl.mul_sel = MUL_STEP_ROW;
         ST_MUL_ROW:  ctrl.mul_sel = MUL_STEP_ROW;
         ST_MUL_COL: begin
            ctrl.mul_sel = MUL_STEP_COL;
            ctrl.load_cr = 1'b1;
         end
         ST_FIRST_SQ: begin
            ctrl.mul_sel = MUL_A_A;
            ctrl.load_ci = 1'b1;
         end
         ST_SQ_A:     ctrl.mul_sel = MUL_A_A;
         ST_SQ_B: begin
            ctrl.mul_sel = MUL_B_B;
            ctrl.load_aa = 1'b1;
         end
         ST_PROD_AB: begin
            ctrl.mul_sel = MUL_A_B;
            ctrl.load_bb = 1'b1;
         end
         ST_TEST: begin
            ctrl.mul_sel = MUL_A_B;
            ctrl.iterate = !stop;
            ctrl.done    = stop && out_free;
         end
         default:     ctrl.mul_sel = MUL_A_B;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start && state_ff == ST_IDLE) begin
         row_ff <= row;
         col_ff <= col;
      end
      if (ctrl.load_cr) begin
         cr_ff <= sat32($signed(c_sum));
         a_ff  <= sat32($signed(c_sum));
      end
      if (ctrl.load_ci) begin
         ci_ff <= sat32($signed(c_sum));
         b_ff  <= sat32($signed(c_sum));
         n_ff  <= '0;
      end
      if (ctrl.load_aa) begin
         aa_ff <= prod_q;
      end
      if (ctrl.load_bb) begin
         bb_ff <= prod_q;
      end
      if (ctrl.iterate) begin
         a_ff <= sat32(na_sum);
         b_ff <= sat32(nb_sum);
         n_ff <= n_ff + 1'b1;
      end
   end

   assign busy         = (state_ff != ST_IDLE);
   assign done         = ctrl.done;
   assign pixel_index  = (PIX_W'(row_ff) << WIDTH_LOG2) + PIX_W'(col_ff);
   assign escape_count = (n_ff == cfg.max_iter) ? '0 : n_ff;
endmodule

// File: src/mandelbrot_escape_time.sv
// Mandelbrot escape-time unit, signed Q4.28 fixed point. Each request transaction carries
// one pixel (row, col); the pixel maps to c = center - width/2 + (width/HEIGHT) * (row, col),
// with rows on the real axis and columns on the imaginary axis, and z = a + ib is iterated
// as a' = 2ab + c_re, b' = b*b - a*a + c_im until a*a + b*b exceeds 4.0 or max_iter is
// reached. The response transaction gives the pixel index, the count (0 when the limit was
// reached) and the count modulo 256 as a gray level. All products go through one
// registered 32x32 multiplier: after setup every iteration computes a*a, b*b and a*b, then
// the update, so a pixel occupies the unit for longer the more iterations it needs;
// req_tready is low meanwhile. One finished response is held in an output register, so the
// next pixel may start while it waits. The user must write configuration registers only
// while the unit is idle; the unit itself does not enforce this.
module mandelbrot_escape_time (
   input  logic                              clock,
   input  logic                              reset,
   // row, col
   input  logic [23:0]                       req_tdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // pixel_index, escape_count, gray_level
   output logic [47:0]                       rsp_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_wr_en,
   input  logic [mbet_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mbet_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import mbet_pkg::*;

   cfg_type            cfg_ff;
   logic               busy, done, out_free;
   logic [PIX_W-1:0]   pixel_index;
   logic [COUNT_W-1:0] escape_count;
   logic [PIX_W-1:0]   rsp_pixel_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic               rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.center_real <= RST_CENTER_REAL;
         cfg_ff.center_imag <= RST_CENTER_IMAG;
         cfg_ff.area_width  <= RST_AREA_WIDTH;
         cfg_ff.max_iter    <= RST_MAX_ITER;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CENTER_REAL: cfg_ff.center_real <= csr_wdata;
            CSR_CENTER_IMAG: cfg_ff.center_imag <= csr_wdata;
            CSR_AREA_WIDTH:  cfg_ff.area_width  <= csr_wdata;
            CSR_MAX_ITER:    cfg_ff.max_iter    <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign req_tready = !busy;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   mbet_core u_core (
      .clock        (clock),
      .reset        (reset),
      .start        (req_tvalid && req_tready),
      .row          (req_tdata[COORD_W-1:0]),
      .col          (req_tdata[2*COORD_W-1:COORD_W]),
      .cfg          (cfg_ff),
      .out_free     (out_free),
      .busy         (busy),
      .done         (done),
      .pixel_index  (pixel_index),
      .escape_count (escape_count)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_pixel_ff <= pixel_index;
         rsp_count_ff <= escape_count;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_count_ff[GRAY_W-1:0], rsp_count_ff, rsp_pixel_ff};
endmodule
